// ===== hdl/tmcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tmcw_pkg - text mode console writer package
// Command codes, character codes and word layouts used by the console writer.
// ----------------------------------------------------------------------------
package tmcw_pkg;

  typedef enum logic [2:0] {
    CMD_PUT_CHAR  = 3'd0,
    CMD_SET_POS   = 3'd1,
    CMD_SET_ATTR  = 3'd2,
    CMD_CLEAR     = 3'd3,
    CMD_READ_CELL = 3'd4
  } cmd_t;

  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] ATTR_RESET = 8'h0F;

  localparam int CMD_W    = 3;
  localparam int CHAR_W   = 8;
  localparam int COL_IN_W = 7;
  localparam int ROW_IN_W = 5;
  localparam int ATTR_W   = 8;
  localparam int CELL_W   = 16;
  localparam int CURPOS_W = 11;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 32;

endpackage

// ===== hdl/tmcw_ram.sv =====
// ----------------------------------------------------------------------------
// tmcw_ram - screen cell store
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module tmcw_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/text_mode_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_mode_console_writer - COLUMNS x ROWS text console
// Screen store with cursor, attribute, scroll and clear sequencing.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one word per command - put char, set position,
//   set attribute, clear screen, read cell. Each accepted word yields
//   exactly one result word on the out_* channel carrying the cursor index
//   after the command and, for read cell, the cell read (else zero).
//   Result path, from accept to out_tvalid: set position, set attribute
//   and a plain put char go through the done state to the output register;
//   read cell passes the read state first; clear screen passes a fill of
//   all COLUMNS*ROWS cells; a put char or LF that scrolls passes the row
//   copy of the scroll state and then a fill of the last row.
//   A new command is taken once the previous one has passed its result to
//   the output register: a plain command is accepted in the idle state and
//   handed over from the done state before the next one can be taken. Scroll
//   and clear use the single write port of the cell memory: scroll copies
//   one cell per cycle, clear writes one cell per cycle.
//   Reset: the cursor goes home, the attribute to 0x0F, and a clearing
//   pass over all COLUMNS*ROWS cells (2000 by default) zeroes the screen;
//   no input is taken during it and it gives no result.
//   Receiver stall: the result waits in the output register; one further
//   command may be accepted and completes up to its hand-over, then holds.
// ----------------------------------------------------------------------------
module text_mode_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // lsb up: command[2:0], char_code[10:3], column[17:11], row[22:18],
  //         attr_value[30:23], zero pad [31]
  input  logic [tmcw_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // lsb up: cursor_position[10:0], cell_data[26:11], zero pad [31:27]
  output logic [tmcw_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  import tmcw_pkg::*;

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int AW     = $clog2(CELLS);
  localparam int CW     = $clog2(COLUMNS);
  localparam int RW     = $clog2(ROWS);
  localparam int COPY_N = CELLS - COLUMNS;

  localparam logic [AW-1:0] COPY_A = AW'(COPY_N);
  localparam logic [AW-1:0] LAST_A = AW'(CELLS - 1);
  localparam logic [AW-1:0] COLS_A = AW'(COLUMNS);
  localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
  localparam int OUT_PAD = OUT_TDATA_W - CELL_W - CURPOS_W;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_READ   = 5'b00010,
    ST_SCROLL = 5'b00100,
    ST_FILL   = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [AW-1:0]        cnt_r, cnt_nxt;
  logic [RW-1:0]        row_r, row_nxt;
  logic [CW-1:0]        col_r, col_nxt;
  logic [ATTR_W-1:0]    attr_r, attr_nxt;
  logic [ATTR_W-1:0]    fill_r, fill_nxt;
  logic [CELL_W-1:0]    data_r, data_nxt;
  logic                 boot_r, boot_nxt;
  logic                 out_valid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  // input word fields
  cmd_t                 in_cmd;
  logic [CHAR_W-1:0]    in_char;
  logic [COL_IN_W-1:0]  in_col;
  logic [ROW_IN_W-1:0]  in_row;
  logic [ATTR_W-1:0]    in_attr;
  logic                 in_fire;

  logic [CW-1:0]        sat_col;
  logic [RW-1:0]        sat_row;
  logic [AW-1:0]        sel_addr;
  logic [AW-1:0]        cur_addr;
  logic [AW+CURPOS_W-1:0] cur_ext;
  logic                 out_free;

  // memory port
  logic                 mem_we;
  logic [AW-1:0]        mem_wa;
  logic [CELL_W-1:0]    mem_wd;
  logic                 mem_re;
  logic [AW-1:0]        mem_ra;
  logic [CELL_W-1:0]    mem_rd;

  assign in_cmd  = cmd_t'(in_tdata[2:0]);
  assign in_char = in_tdata[10:3];
  assign in_col  = in_tdata[17:11];
  assign in_row  = in_tdata[22:18];
  assign in_attr = in_tdata[30:23];

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // saturate requested position onto the screen
  assign sat_col = ({2'b00, in_col} >= 9'(COLUMNS)) ? COL_LAST : CW'(in_col);
  assign sat_row = ({4'b0000, in_row} >= 9'(ROWS)) ? ROW_LAST : RW'(in_row);
  assign sel_addr = AW'(sat_row * COLUMNS + sat_col);
  assign cur_addr = AW'(row_r * COLUMNS + col_r);
  assign cur_ext  = {{CURPOS_W{1'b0}}, cur_addr};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    attr_nxt  = attr_r;
    fill_nxt  = fill_r;
    data_nxt  = data_r;
    boot_nxt  = boot_r;
    mem_we    = 1'b0;
    mem_wa    = cur_addr;
    mem_wd    = {attr_r, in_char};
    mem_re    = 1'b0;
    mem_ra    = sel_addr;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          data_nxt  = '0;
          state_nxt = ST_DONE;
          case (in_cmd)
            CMD_PUT_CHAR: begin
              if (in_char == CHAR_CR) begin
                col_nxt = '0;
              end else if (in_char == CHAR_LF) begin
                col_nxt = '0;
                if (row_r == ROW_LAST) begin
                  state_nxt = ST_SCROLL;
                  cnt_nxt   = '0;
                end else begin
                  row_nxt = row_r + RW'(1);
                end
              end else begin
                mem_we = 1'b1;
                if (col_r == COL_LAST) begin
                  col_nxt = '0;
                  if (row_r == ROW_LAST) begin
                    state_nxt = ST_SCROLL;
                    cnt_nxt   = '0;
                  end else begin
                    row_nxt = row_r + RW'(1);
                  end
                end else begin
                  col_nxt = col_r + CW'(1);
                end
              end
            end
            CMD_SET_POS: begin
              row_nxt = sat_row;
              col_nxt = sat_col;
            end
            CMD_SET_ATTR: begin
              attr_nxt = in_attr;
            end
            CMD_CLEAR: begin
              row_nxt   = '0;
              col_nxt   = '0;
              fill_nxt  = in_attr;
              cnt_nxt   = '0;
              state_nxt = ST_FILL;
            end
            CMD_READ_CELL: begin
              mem_re    = 1'b1;
              state_nxt = ST_READ;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        data_nxt  = mem_rd;
        state_nxt = ST_DONE;
      end
      ST_SCROLL: begin
        // read one row ahead, write the cell read last cycle one row up
        mem_re = (cnt_r < COPY_A);
        mem_ra = cnt_r + COLS_A;
        mem_we = (cnt_r != '0);
        mem_wa = cnt_r - AW'(1);
        mem_wd = mem_rd;
        if (cnt_r == COPY_A) begin
          fill_nxt  = attr_r;
          state_nxt = ST_FILL;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      ST_FILL: begin
        mem_we = 1'b1;
        mem_wa = cnt_r;
        mem_wd = {fill_r, {CHAR_W{1'b0}}};
        if (cnt_r == LAST_A) begin
          state_nxt = boot_r ? ST_IDLE : ST_DONE;
          boot_nxt  = 1'b0;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
      cnt_r   <= '0;
      row_r   <= '0;
      col_r   <= '0;
      attr_r  <= ATTR_RESET;
      fill_r  <= '0;
      boot_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      attr_r  <= attr_nxt;
      fill_r  <= fill_nxt;
      boot_r  <= boot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_tdata_r <= {{OUT_PAD{1'b0}}, data_r, cur_ext[CURPOS_W-1:0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  tmcw_ram #(
    .DEPTH (CELLS),
    .AW    (AW),
    .DW    (CELL_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_en   (mem_re),
    .rd_addr (mem_ra),
    .rd_data (mem_rd)
  );

endmodule
